// ===== hdl/lsp_pkg.sv =====
// ----------------------------------------------------------------------------
// LED slot player package
// Shared types and constants of the multi-slot LED pattern player.
// ----------------------------------------------------------------------------
package lsp_pkg;

  localparam int OP_W      = 2;
  localparam int ADDR_W    = 6;
  localparam int DUR_W     = 16;
  localparam int LEN_W     = 7;
  localparam int SLOT_W    = 3;
  localparam int STATUS_W  = 2;
  localparam int SLOT_ID_W = 2;
  localparam int LED_W     = 4;
  localparam int STEP_W    = 6;
  localparam int ADDR_SPAN = 2 ** ADDR_W;

  // Longest pattern that the six-bit step index can walk through.
  localparam logic [LEN_W-1:0] MAX_STEPS = 7'd64;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_TICK  = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_NO_FREE = 2'd2
  } status_e;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [ADDR_W-1:0] address;
    logic [DUR_W-1:0]  duration;
    logic              initial_level;
    logic [LEN_W-1:0]  length;
    logic              loop_mode;
    logic [SLOT_W-1:0] slot;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [SLOT_ID_W-1:0] slot_id;
    logic [LED_W-1:0]     led_levels;
    logic [LED_W-1:0]     active_slots;
  } out_item_t;

  // Per-slot command strobes from the decoder.
  typedef struct packed {
    logic wr_en;
    logic start_en;
    logic stop_en;
    logic tick_en;
    logic init_level;
    logic loop_mode;
  } slot_cmd_t;

  // Per-slot flags, both current and as they will be after this cycle.
  typedef struct packed {
    logic active;
    logic level;
    logic active_nx;
    logic level_nx;
  } slot_stat_t;

endpackage

// ===== hdl/lsp_if.sv =====
// ----------------------------------------------------------------------------
// LED slot player channels
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface lsp_in_if;
  import lsp_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lsp_out_if;
  import lsp_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/lsp_slot.sv =====
// ----------------------------------------------------------------------------
// LED slot player, one slot
// Slot state, countdown and a private copy of the pattern store.
// ----------------------------------------------------------------------------
module lsp_slot #(
  parameter int  PATTERN_WORDS = 64,
  parameter int  DURATION_BITS = 16,
  localparam int AW            = $clog2(PATTERN_WORDS)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lsp_pkg::slot_cmd_t            cmd_i,
  input  logic [AW-1:0]                 wr_addr_i,
  input  logic [DURATION_BITS-1:0]      wr_data_i,
  input  logic [AW-1:0]                 base_i,
  input  logic [lsp_pkg::LEN_W-1:0]     len_i,
  output lsp_pkg::slot_stat_t           stat_o
);
  import lsp_pkg::*;

  localparam logic [AW-1:0]            LAST_WORD = AW'(PATTERN_WORDS - 1);
  localparam logic [DURATION_BITS-1:0] ONE_TICK  = DURATION_BITS'(1);

  logic                     active_q, active_d;
  logic                     level_q, level_d;
  logic                     loop_q, loop_d;
  logic [AW-1:0]            base_q, base_d;
  logic [LEN_W-1:0]         len_q, len_d;
  logic [STEP_W-1:0]        step_q, step_d;
  logic [AW-1:0]            ptr_q, ptr_d;
  logic [DURATION_BITS-1:0] rem_q, rem_d;
  logic                     pend_q, pend_d;
  logic [DURATION_BITS-1:0] rd_q;
  logic [DURATION_BITS-1:0] mem_q [PATTERN_WORDS];

  logic                     rd_en;
  logic [DURATION_BITS-1:0] eff;
  logic [LEN_W-1:0]         step_nx;
  logic [AW-1:0]            ptr_nx;

  // A freshly loaded step keeps its duration in the read register until the
  // first tick moves it into the countdown. A stored zero counts as one tick.
  always_comb begin
    active_d = active_q;
    level_d  = level_q;
    loop_d   = loop_q;
    base_d   = base_q;
    len_d    = len_q;
    step_d   = step_q;
    ptr_d    = ptr_q;
    rem_d    = rem_q;
    pend_d   = pend_q;
    rd_en    = 1'b0;
    eff      = pend_q ? ((rd_q == '0) ? ONE_TICK : rd_q) : rem_q;
    step_nx  = {1'b0, step_q} + 7'd1;
    ptr_nx   = (ptr_q == LAST_WORD) ? '0 : ptr_q + AW'(1);

    priority if (cmd_i.start_en) begin
      active_d = 1'b1;
      level_d  = cmd_i.init_level;
      loop_d   = cmd_i.loop_mode;
      base_d   = base_i;
      len_d    = len_i;
      step_d   = '0;
      ptr_d    = base_i;
      rd_en    = 1'b1;
      pend_d   = 1'b1;
    end else if (cmd_i.stop_en) begin
      active_d = 1'b0;
      pend_d   = 1'b0;
      rem_d    = '0;
    end else if (cmd_i.tick_en && active_q) begin
      if (eff > ONE_TICK) begin
        rem_d  = eff - ONE_TICK;
        pend_d = 1'b0;
      end else begin
        level_d = !level_q;
        if (step_nx >= len_q) begin
          if (loop_q) begin
            step_d = '0;
            ptr_d  = base_q;
            rd_en  = 1'b1;
            pend_d = 1'b1;
          end else begin
            active_d = 1'b0;
            pend_d   = 1'b0;
            rem_d    = '0;
          end
        end else begin
          step_d = step_nx[STEP_W-1:0];
          ptr_d  = ptr_nx;
          rd_en  = 1'b1;
          pend_d = 1'b1;
        end
      end
    end else begin
      pend_d = pend_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      level_q  <= 1'b0;
      loop_q   <= 1'b0;
      base_q   <= '0;
      len_q    <= '0;
      step_q   <= '0;
      ptr_q    <= '0;
      rem_q    <= '0;
      pend_q   <= 1'b0;
    end else begin
      active_q <= active_d;
      level_q  <= level_d;
      loop_q   <= loop_d;
      base_q   <= base_d;
      len_q    <= len_d;
      step_q   <= step_d;
      ptr_q    <= ptr_d;
      rem_q    <= rem_d;
      pend_q   <= pend_d;
    end
  end

  // Every slot holds a full copy of the store, so all slots can load a new
  // step in the same cycle. Writes never coincide with loads.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en) begin
      rd_q <= mem_q[ptr_d];
    end
  end

  assign stat_o.active    = active_q;
  assign stat_o.level     = level_q;
  assign stat_o.active_nx = active_d;
  assign stat_o.level_nx  = level_d;

endmodule

// ===== hdl/multi_slot_led_pattern_player_top.sv =====
// ----------------------------------------------------------------------------
// Multi-slot LED pattern player
// Plays toggle patterns from a shared duration store on several LED slots.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake      Payload
//  in_i     in   valid / ready  operation, address, duration, initial_level,
//                               length, loop_mode, slot
//  res_o    out  valid / ready  status, slot_id, led_levels, active_slots
//
//  One item is accepted per cycle unless a stalled result holds the pipe; its
//  result passes the input register, then the result register, before it is
//  offered on res_o.
//  All slots count down and load their next step in parallel; each slot reads
//  its own copy of the pattern store, one port per slot.
//  Reset clears all slot state at once; the pattern store is not cleared.
//  A stalled result holds the result register, and the input register keeps
//  one more item before in_i.ready drops.
//
module multi_slot_led_pattern_player_top #(
  parameter int SLOTS         = 4,
  parameter int PATTERN_WORDS = 64,
  parameter int DURATION_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lsp_in_if.sink    in_i,
  lsp_out_if.source res_o
);
  import lsp_pkg::*;

  localparam int AW = $clog2(PATTERN_WORDS);

  typedef logic [AW-1:0] waddr_t;
  typedef waddr_t mod_tbl_t [ADDR_SPAN];

  function automatic mod_tbl_t mod_table();
    mod_tbl_t tbl;
    for (int i = 0; i < ADDR_SPAN; i++) begin
      tbl[i] = AW'(i % PATTERN_WORDS);
    end
    return tbl;
  endfunction

  // Store address of every possible address field value.
  localparam mod_tbl_t ADDR_MOD = mod_table();

  logic       in_vld_q;
  in_item_t   in_q;
  logic       res_vld_q;
  out_item_t  res_q, res_d;

  logic             s2_free;
  logic             fire;
  op_e              op;
  logic             found;
  logic [SLOT_W-1:0] grant;
  logic [LEN_W-1:0] len_sat;
  logic             stop_bad;
  waddr_t           addr_mod;

  slot_cmd_t  cmd [SLOTS];
  slot_stat_t stat [SLOTS];
  logic [SLOTS-1:0] active;

  assign s2_free     = !res_vld_q || res_o.ready;
  assign fire        = in_vld_q && s2_free;
  assign in_i.ready  = !in_vld_q || s2_free;
  assign res_o.valid = res_vld_q;
  assign res_o.data  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_vld_q <= in_i.valid;
      end
      if (fire) begin
        res_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q <= in_i.data;
    end
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign op       = op_e'(in_q.operation);
  assign len_sat  = (in_q.length > MAX_STEPS) ? MAX_STEPS : in_q.length;
  assign stop_bad = ({1'b0, in_q.slot} >= (SLOT_W + 1)'(SLOTS));
  assign addr_mod = ADDR_MOD[in_q.address];

  // Lowest-numbered idle slot wins a start.
  always_comb begin
    found = 1'b0;
    grant = '0;
    for (int s = 0; s < SLOTS; s++) begin
      if (!found && !active[s]) begin
        found = 1'b1;
        grant = SLOT_W'(s);
      end
    end
  end

  for (genvar s = 0; s < SLOTS; s++) begin : g_slot
    assign cmd[s].wr_en      = fire && (op == OP_WRITE);
    assign cmd[s].start_en   = fire && (op == OP_START) && (in_q.length != '0) &&
                               found && (grant == SLOT_W'(s));
    assign cmd[s].stop_en    = fire && (op == OP_STOP) && (in_q.slot == SLOT_W'(s));
    assign cmd[s].tick_en    = fire && (op == OP_TICK);
    assign cmd[s].init_level = in_q.initial_level;
    assign cmd[s].loop_mode  = in_q.loop_mode;
    assign active[s]         = stat[s].active;

    lsp_slot #(
      .PATTERN_WORDS (PATTERN_WORDS),
      .DURATION_BITS (DURATION_BITS)
    ) u_slot (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (cmd[s]),
      .wr_addr_i (addr_mod),
      .wr_data_i (DURATION_BITS'(in_q.duration)),
      .base_i    (addr_mod),
      .len_i     (len_sat),
      .stat_o    (stat[s])
    );
  end

  always_comb begin
    res_d.status       = ST_OK;
    res_d.slot_id      = '0;
    res_d.led_levels   = '0;
    res_d.active_slots = '0;
    unique case (op)
      OP_WRITE: res_d.status = ST_OK;
      OP_START: begin
        if (in_q.length == '0) begin
          res_d.status = ST_INVALID;
        end else if (!found) begin
          res_d.status = ST_NO_FREE;
        end else begin
          res_d.slot_id = grant[SLOT_ID_W-1:0];
        end
      end
      OP_STOP: begin
        if (stop_bad) begin
          res_d.status = ST_INVALID;
        end
      end
      OP_TICK: res_d.status = ST_OK;
      default: res_d.status = ST_OK;
    endcase
    for (int i = 0; i < SLOTS && i < LED_W; i++) begin
      res_d.led_levels[i]   = stat[i].level_nx;
      res_d.active_slots[i] = stat[i].active_nx;
    end
  end

  // A start with a free slot and a nonzero length must succeed.
  a_start_grants: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (op == OP_START) && (in_q.length != '0) && !(&active)
    |=> res_vld_q && (res_q.status == ST_OK))
    else $error("start with a free slot was not granted");

  // A start while every slot is busy reports no free slot.
  a_start_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (op == OP_START) && (in_q.length != '0) && (&active)
    |=> res_q.status == ST_NO_FREE)
    else $error("start with all slots busy was granted");

  // An item waiting in the input register is kept until it moves on.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !s2_free |=> in_vld_q && $stable(in_q))
    else $error("input register lost a waiting item");

  // Every processed item yields a result in the next cycle.
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> res_vld_q)
    else $error("processed item produced no result");

endmodule

// ===== test/multi_slot_led_pattern_player_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Multi-slot LED pattern player testbench
// Drives command items through a bursty sender into the player. Each accepted
// item is fed to a behavioral model of the slots and the duration store.
// The result items, taken under a stalling receiver, are checked field by
// field against the predicted ones, in order.
// ----------------------------------------------------------------------------
module multi_slot_led_pattern_player_top_test;
  import lsp_pkg::*;

  localparam int NUM_SLOTS    = 4;
  localparam int STORE_WORDS  = 64;
  localparam int RANDOM_ITEMS = 800;
  localparam int IDLE_LIMIT   = 3000;
  localparam int DRAIN_CYCLES = 10;
  localparam int HOLD_CYCLES  = 150;
  localparam int HOLD_AFTER   = 300;
  localparam int MAX_REPORTS  = 40;

  logic clk_i = 1'b0;
  logic rst_ni;

  lsp_in_if  cmd_ch ();
  lsp_out_if res_ch ();

  multi_slot_led_pattern_player_top #(
    .SLOTS        (NUM_SLOTS),
    .PATTERN_WORDS(STORE_WORDS),
    .DURATION_BITS(DUR_W)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (cmd_ch),
    .res_o (res_ch)
  );

  always #5 clk_i = ~clk_i;

  // Behavioral copy of the player state.
  bit              slot_on     [NUM_SLOTS];
  bit              slot_led    [NUM_SLOTS];
  bit              slot_loops  [NUM_SLOTS];
  bit [ADDR_W-1:0] slot_base   [NUM_SLOTS];
  bit [LEN_W-1:0]  slot_len    [NUM_SLOTS];
  int              slot_step   [NUM_SLOTS];
  bit [DUR_W-1:0]  slot_left   [NUM_SLOTS];
  bit [DUR_W-1:0]  duration_store [STORE_WORDS];

  in_item_t  pending_cmds[$];
  out_item_t expected_results[$];
  bit        word_written[STORE_WORDS];

  int total_cmds;
  int cmds_sent;
  int results_checked;
  int error_count;
  int idle_cycles;
  int hold_left;
  bit hold_done;
  int burst_left;
  int gap_left;
  int mode_left;
  int stall_mode;
  int stall_phase;
  out_item_t next_result;

  function automatic bit [DUR_W-1:0] step_ticks(int s);
    bit [DUR_W-1:0] d;
    d = duration_store[(int'(slot_base[s]) + slot_step[s]) % STORE_WORDS];
    return (d == '0) ? DUR_W'(1) : d;
  endfunction

  function automatic void tick_slot(int s);
    if (!slot_on[s]) return;
    if (slot_left[s] > 1) begin
      slot_left[s]--;
      return;
    end
    slot_led[s] = ~slot_led[s];
    slot_step[s]++;
    if (slot_step[s] >= int'(slot_len[s])) begin
      if (slot_loops[s]) begin
        slot_step[s] = 0;
      end else begin
        slot_on[s]   = 1'b0;
        slot_left[s] = '0;
        return;
      end
    end
    slot_left[s] = step_ticks(s);
  endfunction

  function automatic out_item_t play_cmd(in_item_t it);
    out_item_t r;
    bit granted;
    r = '0;
    granted = 1'b0;
    case (op_e'(it.operation))
      OP_WRITE: duration_store[it.address] = it.duration;
      OP_START: begin
        if (it.length == '0) begin
          r.status = ST_INVALID;
        end else begin
          r.status = ST_NO_FREE;
          for (int s = 0; s < NUM_SLOTS; s++) begin
            if (!granted && !slot_on[s]) begin
              granted       = 1'b1;
              slot_on[s]    = 1'b1;
              slot_led[s]   = it.initial_level;
              slot_loops[s] = it.loop_mode;
              slot_base[s]  = it.address;
              slot_len[s]   = (it.length > MAX_STEPS) ? MAX_STEPS : it.length;
              slot_step[s]  = 0;
              slot_left[s]  = step_ticks(s);
              r.status      = ST_OK;
              r.slot_id     = SLOT_ID_W'(s);
            end
          end
        end
      end
      OP_STOP: begin
        if (it.slot >= NUM_SLOTS) begin
          r.status = ST_INVALID;
        end else begin
          slot_on[it.slot]   = 1'b0;
          slot_left[it.slot] = '0;
        end
      end
      default: begin
        for (int s = 0; s < NUM_SLOTS; s++) tick_slot(s);
      end
    endcase
    for (int s = 0; s < NUM_SLOTS; s++) begin
      r.led_levels[s]   = slot_led[s];
      r.active_slots[s] = slot_on[s];
    end
    return r;
  endfunction

  // Fields that the operation ignores still carry random bits.
  function automatic in_item_t random_cmd(op_e op);
    logic [63:0] r;
    in_item_t it;
    r = {$urandom, $urandom};
    it = r[$bits(in_item_t)-1:0];
    it.operation = op;
    return it;
  endfunction

  function automatic int pick_duration();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return $urandom_range(0, 4);
    if (r < 18) return $urandom_range(0, 20);
    if (r == 18) return $urandom_range(0, 65535);
    return ($urandom_range(0, 1) == 0) ? 0 : 65535;
  endfunction

  task automatic add_write(int addr, int dur);
    in_item_t it;
    it = random_cmd(OP_WRITE);
    it.address  = ADDR_W'(addr);
    it.duration = DUR_W'(dur);
    word_written[addr % STORE_WORDS] = 1'b1;
    pending_cmds.push_back(it);
  endtask

  // Any store word that the pattern will read is written first.
  task automatic add_start(int base, int len, bit init, bit lp);
    in_item_t it;
    int steps;
    steps = (len > int'(MAX_STEPS)) ? int'(MAX_STEPS) : len;
    for (int k = 0; k < steps; k++) begin
      if (!word_written[(base + k) % STORE_WORDS])
        add_write((base + k) % STORE_WORDS, pick_duration());
    end
    it = random_cmd(OP_START);
    it.address       = ADDR_W'(base);
    it.length        = LEN_W'(len);
    it.initial_level = init;
    it.loop_mode     = lp;
    pending_cmds.push_back(it);
  endtask

  task automatic add_stop(int sl);
    in_item_t it;
    it = random_cmd(OP_STOP);
    it.slot = SLOT_W'(sl);
    pending_cmds.push_back(it);
  endtask

  task automatic add_tick();
    pending_cmds.push_back(random_cmd(OP_TICK));
  endtask

  task automatic report_mismatch(string what, int got, int want);
    if (error_count < MAX_REPORTS)
      $display("mismatch at result %0d: %s got %0h expected %0h",
               results_checked, what, got, want);
    error_count++;
  endtask

  task automatic build_stimulus();
    int choice;
    int len;
    int base;
    // Directed opening: idle operations, zero length, wrapping pattern,
    // zero and full durations, every slot taken, then no free slot.
    add_tick();
    add_stop(0);
    add_stop(7);
    add_stop(4);
    add_start(63, 0, 1'b1, 1'b1);
    add_write(62, 1);
    add_write(63, 0);
    add_write(0, 65535);
    add_write(1, 2);
    add_start(62, 3, 1'b1, 1'b1);
    add_tick();
    add_tick();
    add_start(63, 1, 1'b0, 1'b0);
    add_start(1, 1, 1'b1, 1'b1);
    add_start(0, 2, 1'b0, 1'b0);
    add_start(1, 1, 1'b0, 1'b1);
    add_tick();
    add_stop(1);
    add_stop(3);
    add_stop(2);
    add_write(32, 16'h5AA5);

    total_cmds = pending_cmds.size() + RANDOM_ITEMS;
    while (pending_cmds.size() < total_cmds) begin
      choice = $urandom_range(0, 99);
      if (choice < 8) begin
        add_write($urandom_range(0, STORE_WORDS - 1),
                  ($urandom_range(0, 1) == 0) ? $urandom_range(0, 65535) : pick_duration());
      end else if (choice < 28) begin
        base = $urandom_range(0, STORE_WORDS - 1);
        choice = $urandom_range(0, 99);
        if (choice < 5) len = 0;
        else if (choice < 10) len = int'(MAX_STEPS);
        else if (choice < 13) len = $urandom_range(65, 127);
        else len = $urandom_range(1, 8);
        // In four cases of ten, a short pattern is programmed afresh right before its start.
        if (len > 0 && len <= 8 && $urandom_range(0, 9) < 4) begin
          for (int k = 0; k < len; k++)
            add_write((base + k) % STORE_WORDS, pick_duration());
        end
        add_start(base, len, 1'($urandom), 1'($urandom));
      end else if (choice < 38) begin
        add_stop(($urandom_range(0, 4) != 0) ? $urandom_range(0, 3) : $urandom_range(4, 7));
      end else begin
        add_tick();
      end
    end
    total_cmds = pending_cmds.size();
  endtask

  initial begin
    rst_ni       = 1'b0;
    cmd_ch.valid = 1'b0;
    cmd_ch.data  = '0;
    res_ch.ready = 1'b0;
    build_stimulus();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (cmds_sent == total_cmds);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_ch.valid <= 1'b0;
      cmd_ch.data  <= '0;
      burst_left = 1;
      gap_left   = 0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        expected_results.push_back(play_cmd(cmd_ch.data));
        cmds_sent++;
      end
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (gap_left > 0 || pending_cmds.size() == 0) begin
          if (gap_left > 0) gap_left--;
          cmd_ch.valid <= 1'b0;
        end else begin
          cmd_ch.valid <= 1'b1;
          cmd_ch.data  <= pending_cmds.pop_front();
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
    end
  end

  // One long hold-off of the receiver, so that the player backs up.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && results_checked >= HOLD_AFTER) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver: switches between always ready, coin flips and a 3-of-4 pattern.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
      mode_left   = 0;
      stall_mode  = 0;
      stall_phase = 0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left  = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      stall_phase++;
      case (stall_mode)
        0:       res_ch.ready <= (hold_left == 0);
        1:       res_ch.ready <= (hold_left == 0) && ($urandom_range(0, 1) == 1);
        default: res_ch.ready <= (hold_left == 0) && (stall_phase % 4 != 3);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      results_checked <= results_checked + 1;
      if (expected_results.size() == 0) begin
        report_mismatch("result with none pending", int'(res_ch.data), 0);
      end else begin
        next_result = expected_results.pop_front();
        if (res_ch.data.status !== next_result.status)
          report_mismatch("status", int'(res_ch.data.status), int'(next_result.status));
        if (res_ch.data.slot_id !== next_result.slot_id)
          report_mismatch("slot_id", int'(res_ch.data.slot_id),
                          int'(next_result.slot_id));
        if (res_ch.data.led_levels !== next_result.led_levels)
          report_mismatch("led_levels", int'(res_ch.data.led_levels),
                          int'(next_result.led_levels));
        if (res_ch.data.active_slots !== next_result.active_slots)
          report_mismatch("active_slots", int'(res_ch.data.active_slots),
                          int'(next_result.active_slots));
      end
    end
  end

  // Watchdog on cycles in which neither channel moves an item.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule
